### rtl/core/fastcgi_record_deframer_core_assert.svh
// Assertion macros for the FastCGI record deframer.
`ifndef FASTCGI_RECORD_DEFRAMER_CORE_ASSERT_SVH
`define FASTCGI_RECORD_DEFRAMER_CORE_ASSERT_SVH
// Check a property on every rising clock edge outside reset.
`define FRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define FRD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`endif

### rtl/core/frd_pkg.sv
// Package for the FastCGI record deframer: types and constants.
package frd_pkg;
    localparam logic [7:0] TYPE_STDOUT = 8'd6;
    localparam logic [7:0] TYPE_VALUES = 8'd10;
    localparam logic [3:0] HEADER_LEN  = 4'd8;

    localparam logic [2:0] PH_NAME_LEN  = 3'd0;
    localparam logic [2:0] PH_VALUE_LEN = 3'd1;
    localparam logic [2:0] PH_NAME      = 3'd2;
    localparam logic [2:0] PH_VALUE     = 3'd3;

    // One result beat, fields from the highest bit down.
    typedef struct packed {
        logic        convert_error;
        logic        pairs_malformed;
        logic        mpxs_conns;
        logic [31:0] max_reqs;
        logic [31:0] max_conns;
        logic [15:0] request_id;
        logic [7:0]  record_type;
        logic [7:0]  data_byte;
    } t_result;

    function automatic logic [7:0] name_conns_char(input logic [4:0] pos);
        logic [7:0] c;
        unique case (pos)
            5'd0: c = "F";  5'd1: c = "C";  5'd2: c = "G";  5'd3: c = "I";
            5'd4: c = "_";  5'd5: c = "M";  5'd6: c = "A";  5'd7: c = "X";
            5'd8: c = "_";  5'd9: c = "C";  5'd10: c = "O"; 5'd11: c = "N";
            5'd12: c = "N"; 5'd13: c = "S";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] name_reqs_char(input logic [4:0] pos);
        logic [7:0] c;
        unique case (pos)
            5'd0: c = "F";  5'd1: c = "C";  5'd2: c = "G";  5'd3: c = "I";
            5'd4: c = "_";  5'd5: c = "M";  5'd6: c = "A";  5'd7: c = "X";
            5'd8: c = "_";  5'd9: c = "R";  5'd10: c = "E"; 5'd11: c = "Q";
            5'd12: c = "S";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] name_mpxs_char(input logic [4:0] pos);
        logic [7:0] c;
        unique case (pos)
            5'd0: c = "F";  5'd1: c = "C";  5'd2: c = "G";  5'd3: c = "I";
            5'd4: c = "_";  5'd5: c = "M";  5'd6: c = "P";  5'd7: c = "X";
            5'd8: c = "S";  5'd9: c = "_";  5'd10: c = "C"; 5'd11: c = "O";
            5'd12: c = "N"; 5'd13: c = "N"; 5'd14: c = "S";
            default: c = 8'h00;
        endcase
        return c;
    endfunction
endpackage

### rtl/core/fastcgi_record_deframer_core.sv
// FastCGI record deframer: header decode, STDOUT pass-through, values parse.
// Each result beat is registered in the output stage (or its skid buffer on a stall).
// One byte per cycle while the skid is free; one parse step before the output stage.
// A skid stage keeps input ready while one finished beat waits on the master side.
// Reset (synchronous, active low) clears parser state, flags and learned limits.
module fastcgi_record_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
    input  logic        s_axis_tuser,   // stream_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data_byte[7:0], record_type[15:8], request_id[31:16], max_conns[63:32],
    // max_reqs[95:64], mpxs_conns[96], pairs_malformed[97], convert_error[98], zero pad
    output logic [103:0] m_axis_tdata,
    output logic        m_axis_tuser    // out_kind
);
    import frd_pkg::*;

    logic [3:0]  r_hidx, n_hidx;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_reqid, n_reqid;
    logic [15:0] r_cleft, n_cleft;
    logic [7:0]  r_pleft, n_pleft;
    logic [2:0]  r_phase, n_phase;
    logic [30:0] r_lacc, n_lacc;
    logic [1:0]  r_lcnt, n_lcnt;
    logic [30:0] r_nleft, n_nleft;
    logic [30:0] r_vleft, n_vleft;
    logic [4:0]  r_npos, n_npos;
    logic [2:0]  r_match, n_match;
    logic [31:0] r_dacc, n_dacc;
    logic        r_dbad, n_dbad;
    logic        r_vone, n_vone;
    logic [31:0] r_conns, n_conns;
    logic [31:0] r_reqs, n_reqs;
    logic        r_mpxs, n_mpxs;
    logic        r_stop, n_stop;
    logic        r_err, n_err;
    logic        r_endp, n_endp;

    logic        fire, emit, kind;
    logic [7:0]  b, dbyte;
    logic        len_go;
    logic [30:0] len_val;
    logic [35:0] dig_next;
    logic [31:0] nv_sum;
    t_result     res;

    assign fire = s_axis_tvalid && s_axis_tready;
    assign b    = s_axis_tdata;

    always_comb begin
        n_hidx = r_hidx;  n_type = r_type;  n_reqid = r_reqid;
        n_cleft = r_cleft; n_pleft = r_pleft; n_phase = r_phase;
        n_lacc = r_lacc;  n_lcnt = r_lcnt;  n_nleft = r_nleft;
        n_vleft = r_vleft; n_npos = r_npos; n_match = r_match;
        n_dacc = r_dacc;  n_dbad = r_dbad;  n_vone = r_vone;
        n_conns = r_conns; n_reqs = r_reqs; n_mpxs = r_mpxs;
        n_stop = r_stop;  n_err = r_err;   n_endp = r_endp;
        emit = 1'b0; kind = 1'b1; dbyte = 8'd0;
        len_go = 1'b0; len_val = '0;
        dig_next = '0; nv_sum = '0;

        if (s_axis_tuser) begin
            n_hidx = '0; n_type = '0; n_reqid = '0; n_cleft = '0; n_pleft = '0;
            n_phase = PH_NAME_LEN; n_lacc = '0; n_lcnt = '0; n_nleft = '0;
            n_vleft = '0; n_npos = '0; n_match = '0; n_dacc = '0; n_dbad = 1'b0;
            n_vone = 1'b0; n_stop = 1'b0; n_err = 1'b0; n_endp = 1'b0;
        end

        if (n_hidx < HEADER_LEN) begin
            if (n_hidx == 4'd0) begin
                if (n_endp) begin
                    emit = 1'b1; n_endp = 1'b0;
                end
                n_stop = 1'b0; n_err = 1'b0;
                n_phase = PH_NAME_LEN; n_lacc = '0; n_lcnt = '0; n_nleft = '0;
                n_vleft = '0; n_npos = '0; n_match = '0; n_dacc = '0;
                n_dbad = 1'b0; n_vone = 1'b0;
            end
            unique case (n_hidx)
                4'd1: n_type = b;
                4'd2: n_reqid[15:8] = b;
                4'd3: n_reqid[7:0] = b;
                4'd4: n_cleft[15:8] = b;
                4'd5: n_cleft[7:0] = b;
                4'd6: n_pleft = b;
                default: ;
            endcase
            n_hidx = n_hidx + 4'd1;
            if (n_hidx == HEADER_LEN && n_cleft == '0 && n_pleft == '0) begin
                n_hidx = '0; emit = 1'b1;
            end
        end else begin
            if (n_cleft != '0) begin
                n_cleft = n_cleft - 16'd1;
                if (n_type == TYPE_STDOUT) begin
                    emit = 1'b1; kind = 1'b0; dbyte = b;
                end else if (n_type == TYPE_VALUES && !n_stop) begin
                    if (n_phase <= PH_VALUE_LEN) begin
                        if (n_lcnt != '0) begin
                            n_lacc = {n_lacc[22:0], b};
                            n_lcnt = n_lcnt - 2'd1;
                            if (n_lcnt == '0) begin
                                len_go = 1'b1; len_val = n_lacc;
                            end
                        end else if (b[7]) begin
                            // the three remaining length bytes must fit in this record
                            if (n_cleft < 16'd3) n_stop = 1'b1;
                            else begin
                                n_lacc = {24'd0, b[6:0]}; n_lcnt = 2'd3;
                            end
                        end else begin
                            len_go = 1'b1; len_val = {23'd0, b};
                        end
                        if (len_go) begin
                            if (len_val == '0) n_stop = 1'b1;
                            else if (n_phase == PH_NAME_LEN) begin
                                n_nleft = len_val; n_phase = PH_VALUE_LEN;
                            end else begin
                                n_vleft = len_val;
                                nv_sum = {1'b0, n_nleft} + {1'b0, len_val};
                                if (nv_sum > {16'd0, n_cleft}) n_stop = 1'b1;
                                else begin
                                    n_match = {n_nleft == 31'd15, n_nleft == 31'd13,
                                               n_nleft == 31'd14};
                                    n_npos = '0; n_dacc = '0; n_dbad = 1'b0;
                                    n_vone = (len_val == 31'd1);
                                    n_phase = PH_NAME;
                                end
                            end
                        end
                    end else if (n_phase == PH_NAME) begin
                        if (r_npos > 5'd13 || name_conns_char(n_npos) != b) n_match[0] = 1'b0;
                        if (r_npos > 5'd12 || name_reqs_char(n_npos) != b) n_match[1] = 1'b0;
                        if (r_npos > 5'd14 || name_mpxs_char(n_npos) != b) n_match[2] = 1'b0;
                        if (n_npos < 5'd31) n_npos = n_npos + 5'd1;
                        n_nleft = n_nleft - 31'd1;
                        if (n_nleft == '0) n_phase = PH_VALUE;
                    end else if (n_phase == PH_VALUE) begin
                        if (b != 8'h31) n_vone = 1'b0;
                        if (!n_dbad) begin
                            if (b < 8'h30 || b > 8'h39) n_dbad = 1'b1;
                            else begin
                                dig_next = {1'b0, n_dacc, 3'd0} + {3'd0, n_dacc, 1'b0}
                                         + {32'd0, b[3:0]};
                                if (dig_next[35:32] != '0) n_dbad = 1'b1;
                                else n_dacc = dig_next[31:0];
                            end
                        end
                        n_vleft = n_vleft - 31'd1;
                        if (n_vleft == '0) begin
                            priority if (n_match[0]) begin
                                if (n_dbad) n_err = 1'b1; else n_conns = n_dacc;
                            end else if (n_match[1]) begin
                                if (n_dbad) n_err = 1'b1; else n_reqs = n_dacc;
                            end else if (n_match[2]) begin
                                n_mpxs = n_vone;
                            end else begin
                                // unknown name: drop the value
                            end
                            n_phase = PH_NAME_LEN; n_lacc = '0;
                        end
                    end else begin
                        n_stop = 1'b1;
                    end
                    if (!n_stop && n_cleft == '0 && n_phase == PH_VALUE_LEN) n_stop = 1'b1;
                end
            end else if (n_pleft != '0) begin
                n_pleft = n_pleft - 8'd1;
            end
            if (n_cleft == '0 && n_pleft == '0) begin
                n_hidx = '0;
                if (emit) n_endp = 1'b1;
                else emit = 1'b1;
            end
        end
    end

    // Result fields carry the state after this beat.
    always_comb begin
        res.data_byte       = dbyte;
        res.record_type     = n_type;
        res.request_id      = n_reqid;
        res.max_conns       = n_conns;
        res.max_reqs        = n_reqs;
        res.mpxs_conns      = n_mpxs;
        res.pairs_malformed = n_stop;
        res.convert_error   = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidx <= '0; r_type <= '0; r_reqid <= '0; r_cleft <= '0; r_pleft <= '0;
            r_phase <= PH_NAME_LEN; r_lacc <= '0; r_lcnt <= '0; r_nleft <= '0;
            r_vleft <= '0; r_npos <= '0; r_match <= '0; r_dacc <= '0; r_dbad <= 1'b0;
            r_vone <= 1'b0; r_conns <= '0; r_reqs <= '0; r_mpxs <= 1'b0;
            r_stop <= 1'b0; r_err <= 1'b0; r_endp <= 1'b0;
        end else if (fire) begin
            r_hidx <= n_hidx; r_type <= n_type; r_reqid <= n_reqid; r_cleft <= n_cleft;
            r_pleft <= n_pleft; r_phase <= n_phase; r_lacc <= n_lacc; r_lcnt <= n_lcnt;
            r_nleft <= n_nleft; r_vleft <= n_vleft; r_npos <= n_npos; r_match <= n_match;
            r_dacc <= n_dacc; r_dbad <= n_dbad; r_vone <= n_vone; r_conns <= n_conns;
            r_reqs <= n_reqs; r_mpxs <= n_mpxs; r_stop <= n_stop; r_err <= n_err;
            r_endp <= n_endp;
        end
    end

    t_result out_res;

    frd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fire && emit),
        .o_ready (s_axis_tready),
        .i_data  (res),
        .i_user  (kind),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_res),
        .o_user  (m_axis_tuser)
    );

    assign m_axis_tdata = {5'd0, out_res};

    `include "fastcgi_record_deframer_core_assert.svh"
    `FRD_ASSERT(a_hidx_range, r_hidx <= HEADER_LEN, "header index out of range")
    `FRD_ASSERT(a_endp_body, r_endp |-> (r_hidx == 4'd0), "pending end outside header start")
    `FRD_ASSERT(a_phase_range, r_phase <= PH_VALUE, "pair phase out of range")
endmodule

### rtl/core/frd_out_stage.sv
// Output register with skid buffer for the deframer result beats.
module frd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  frd_pkg::t_result  i_data,
    input  logic              i_user,
    output logic              o_valid,
    input  logic              i_ready,
    output frd_pkg::t_result  o_data,
    output logic              o_user
);
    import frd_pkg::*;

    logic    r_valid, r_skid_valid;
    t_result r_data, r_skid_data;
    logic    r_user, r_skid_user;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_valid || i_ready) begin
                if (r_skid_valid) begin
                    r_valid      <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_valid <= i_valid;
                end
            end else if (i_valid && o_ready) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_valid || i_ready) begin
            if (r_skid_valid) begin
                r_data <= r_skid_data;
                r_user <= r_skid_user;
            end else begin
                r_data <= i_data;
                r_user <= i_user;
            end
        end else if (i_valid && o_ready) begin
            r_skid_data <= i_data;
            r_skid_user <= i_user;
        end
    end

    `include "fastcgi_record_deframer_core_assert.svh"
    `FRD_ASSERT(a_skid_implies_full, !r_skid_valid || r_valid, "skid full with empty output")
    `FRD_ASSERT(a_skid_held, (r_skid_valid && !i_ready) |=> r_skid_valid, "skid beat lost")
    `FRD_ASSERT(a_no_drop, (o_valid && !i_ready) |=> o_valid, "output beat dropped")
endmodule
